// ----- rtl/bba_pkg.sv -----
// Package for the bitmap block allocator: sizes, codes, payload words and the
// request bundle between the controller and the bitmap memory. No dependencies.
package bba_pkg;

  // Store geometry; WORD_BITS is a power of two.
  localparam int NUM_BLOCKS  = 4096;
  localparam int WORD_BITS   = 32;
  localparam int NUM_WORDS   = (NUM_BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int WORD_AW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam int BIT_W       = $clog2(WORD_BITS);

  // Register and field widths.
  localparam int CFG_W       = 13;
  localparam int IDX_W       = 12;
  localparam int FIELD_LIMIT = 4096;
  localparam int LIM_MAX     = (NUM_BLOCKS < FIELD_LIMIT) ? NUM_BLOCKS : FIELD_LIMIT;
  localparam logic [CFG_W-1:0] BLOCK_COUNT_RST = CFG_W'(4096);

  // Compare width covering block numbers, word bases and the limit.
  localparam int CMP_W = ((WORD_AW + 1 + BIT_W) > CFG_W) ? (WORD_AW + 1 + BIT_W) : CFG_W;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_FULL         = 2'd1,
    ST_ALREADY_FREE = 2'd2,
    ST_RANGE        = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_START,
    S_EVAL
  } state_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] block_index;
  } in_item_t;

  typedef struct packed {
    status_e          status;
    logic [IDX_W-1:0] allocated_block;
  } out_item_t;

  typedef struct packed {
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
  } mem_req_t;

endpackage

// ----- rtl/bba_bitmap_ram.sv -----
// Bitmap memory: one-port-read, one-port-write synchronous RAM with a registered
// read port and a valid flop per word so unwritten words read as free. Uses bba_pkg.
module bba_bitmap_ram (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bba_pkg::mem_req_t            req_i,
  output logic [bba_pkg::WORD_BITS-1:0] rd_data_o
);
  import bba_pkg::*;

  logic [WORD_BITS-1:0] mem [NUM_WORDS];
  logic [NUM_WORDS-1:0] valid_q;
  logic [WORD_BITS-1:0] rd_data_q;
  logic                 rd_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (req_i.wr_en) begin
        valid_q[req_i.wr_addr] <= 1'b1;
      end
      if (req_i.rd_en) begin
        rd_valid_q <= valid_q[req_i.rd_addr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem[req_i.wr_addr] <= req_i.wr_data;
    end
    if (req_i.rd_en) begin
      rd_data_q <= mem[req_i.rd_addr];
    end
  end

  // A word never written counts as all free.
  assign rd_data_o = rd_valid_q ? rd_data_q : '0;

`ifndef SYNTHESIS
  a_no_rd_wr_overlap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(req_i.rd_en && req_i.wr_en))
    else $error("bitmap read and write in the same cycle");
`endif

endmodule

// ----- rtl/bba_ctrl.sv -----
// Allocator controller: scans bitmap words for the lowest free block, checks and
// clears bits on free, and writes the modified word back. Uses bba_pkg.
module bba_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  bba_pkg::in_item_t             in_data_i,
  input  logic [bba_pkg::CFG_W-1:0]     limit_i,
  input  logic                          out_free_i,
  output logic                          res_valid_o,
  output bba_pkg::out_item_t            res_o,
  output bba_pkg::mem_req_t             mem_req_o,
  input  logic [bba_pkg::WORD_BITS-1:0] rd_data_i
);
  import bba_pkg::*;

  state_e             state_q, state_d;
  op_e                op_q;
  logic [IDX_W-1:0]   idx_q;
  logic [CFG_W-1:0]   lim_q;
  logic [WORD_AW-1:0] word_q;

  logic               accept;
  logic               done;
  logic               fire;
  logic               issue;
  logic [WORD_AW-1:0] issue_addr;
  status_e            status;
  logic [IDX_W-1:0]   given;
  logic               wr_req;
  logic [WORD_BITS-1:0] wr_word;

  logic               zero_any;
  logic [BIT_W-1:0]   zero_pos;
  logic [CMP_W-1:0]   cand;
  logic [WORD_AW:0]   next_word;
  logic [CMP_W-1:0]   next_base;
  logic [CMP_W-1:0]   lim_ext;
  logic [CMP_W-1:0]   idx_ext;
  logic [BIT_W-1:0]   idx_pos;

  assign accept = in_valid_i && in_ready_o;

  // Lowest clear bit of the word just read.
  always_comb begin
    zero_pos = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!rd_data_i[i]) begin
        zero_pos = BIT_W'(i);
      end
    end
  end

  assign zero_any  = ~&rd_data_i;
  assign cand      = CMP_W'({word_q, zero_pos});
  assign next_word = (WORD_AW + 1)'(word_q) + 1'b1;
  assign next_base = CMP_W'({next_word, {BIT_W{1'b0}}});
  assign lim_ext   = CMP_W'(lim_q);
  assign idx_ext   = CMP_W'(idx_q);
  assign idx_pos   = idx_q[BIT_W-1:0];

  // Decide per cycle: finish with a result, or issue the next word read.
  always_comb begin
    done       = 1'b0;
    issue      = 1'b0;
    issue_addr = word_q;
    status     = ST_OK;
    given      = '0;
    wr_req     = 1'b0;
    wr_word    = rd_data_i;
    case (state_q)
      S_START: begin
        if (op_q == OP_FREE) begin
          if (idx_ext >= lim_ext) begin
            done   = 1'b1;
            status = ST_RANGE;
          end else begin
            issue      = 1'b1;
            issue_addr = idx_ext[BIT_W +: WORD_AW];
          end
        end else begin
          if (lim_q == '0) begin
            done   = 1'b1;
            status = ST_FULL;
          end else begin
            issue      = 1'b1;
            issue_addr = '0;
          end
        end
      end
      S_EVAL: begin
        if (op_q == OP_FREE) begin
          done = 1'b1;
          if (!rd_data_i[idx_pos]) begin
            status = ST_ALREADY_FREE;
          end else begin
            status  = ST_OK;
            wr_req  = 1'b1;
            wr_word = rd_data_i & ~(WORD_BITS'(1) << idx_pos);
          end
        end else if (zero_any) begin
          done = 1'b1;
          if (cand < lim_ext) begin
            status  = ST_OK;
            given   = cand[IDX_W-1:0];
            wr_req  = 1'b1;
            wr_word = rd_data_i | (WORD_BITS'(1) << zero_pos);
          end else begin
            status = ST_FULL;
          end
        end else if (next_base >= lim_ext) begin
          done   = 1'b1;
          status = ST_FULL;
        end else begin
          issue      = 1'b1;
          issue_addr = next_word[WORD_AW-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the result until the output register has room.
  assign fire = done && out_free_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_START;
        end
      end
      S_START, S_EVAL: begin
        if (fire) begin
          state_d = S_IDLE;
        end else if (issue) begin
          state_d = S_EVAL;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o        = (state_q == S_IDLE);
    res_valid_o       = fire;
    res_o.status      = status;
    res_o.allocated_block = given;
    mem_req_o.rd_en   = issue;
    mem_req_o.rd_addr = issue_addr;
    mem_req_o.wr_en   = fire && wr_req;
    mem_req_o.wr_addr = word_q;
    mem_req_o.wr_data = wr_word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= in_data_i.op;
      idx_q <= in_data_i.block_index;
      lim_q <= limit_i;
    end
    if (issue) begin
      word_q <= issue_addr;
    end
  end

`ifndef SYNTHESIS
  a_wr_only_on_ok : assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_req_o.wr_en |-> (res_valid_o && res_o.status == ST_OK))
    else $error("bitmap written without a successful result");
  a_alloc_below_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && op_q == OP_ALLOC && res_o.status == ST_OK)
      |-> (CMP_W'(res_o.allocated_block) < lim_ext))
    else $error("allocated block at or above the limit");
  a_free_gives_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && op_q == OP_FREE) |-> (res_o.allocated_block == '0))
    else $error("free result carries a block number");
`endif

endmodule

// ----- rtl/bitmap_block_allocator.sv -----
// Bitmap block allocator, first fit: a request word enters only when the block is
// idle. A free reads the bitmap word that holds its block (no read when the index
// is out of range); an allocate scans bitmap words from word 0 upward until it
// finds a free block below the limit or reaches the limit. The next request word
// is taken once the controller is idle again, after the result is registered. The
// scan is paced by the single read port of the bitmap RAM, which delivers one
// 32-bit word per cycle. The search limit is the smaller of block_count and 4096.
// After reset every block is free at once: per-word valid flops stand in for
// clearing the RAM, so no clearing pass is needed. Results wait in an output
// register, so the next request can be accepted while one is pending.
// Depends on bba_pkg, bba_ctrl and bba_bitmap_ram.
module bitmap_block_allocator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  bba_pkg::in_item_t         in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output bba_pkg::out_item_t        out_data_o,
  input  logic                      cfg_we_i,
  input  logic [bba_pkg::CFG_W-1:0] cfg_wdata_i
);
  import bba_pkg::*;

  logic [CFG_W-1:0]     block_count_q;
  logic [CFG_W-1:0]     limit;
  logic                 out_valid_q;
  out_item_t            out_q;
  logic                 out_free;
  logic                 res_valid;
  out_item_t            res;
  mem_req_t             mem_req;
  logic [WORD_BITS-1:0] rd_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BLOCK_COUNT_RST;
    end else if (cfg_we_i) begin
      block_count_q <= cfg_wdata_i;
    end
  end

  // Clamp to the store size and the reach of a 12-bit block number.
  assign limit = (int'(block_count_q) > LIM_MAX) ? CFG_W'(LIM_MAX) : block_count_q;

  assign out_free = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  bba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .limit_i     (limit),
    .out_free_i  (out_free),
    .res_valid_o (res_valid),
    .res_o       (res),
    .mem_req_o   (mem_req),
    .rd_data_i   (rd_data)
  );

  bba_bitmap_ram u_ram (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (mem_req),
    .rd_data_o (rd_data)
  );

`ifndef SYNTHESIS
  a_one_at_a_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request word accepted while one is in flight");
`endif

endmodule
